// File: rtl/wildcard_byte_pattern_scanner_top_defines.svh
// Assertion macros for the wildcard byte pattern scanner.
// Define ASSERT_OFF to compile every check away; no other dependencies.
`ifndef WILDCARD_BYTE_PATTERN_SCANNER_TOP_DEFINES_SVH
`define WILDCARD_BYTE_PATTERN_SCANNER_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
// Check a property on every rising edge outside reset
`define WBPS_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Check that a condition is followed by another in the next cycle
`define WBPS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define WBPS_ASSERT(label, clk, rst, prop, msg)
`define WBPS_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// File: rtl/wbps_pkg.sv
// Package for the wildcard byte pattern scanner: payload structs,
// register indexes and fixed field widths. No dependencies.
package wbps_pkg;

  localparam int BYTE_W    = 8;
  localparam int ADDR_W    = 32;
  localparam int CFG_W     = 64;
  localparam int CFG_IDX_W = 2;
  localparam int MASK_W    = 16;
  localparam int LEN_W     = 5;
  localparam int PATTERN_W = 2 * CFG_W;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CARE_MASK    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LEN  = 2'd3;

  // Reset values of the configuration registers
  localparam logic [MASK_W-1:0] CARE_MASK_RESET = 16'hFFFF;
  localparam logic [LEN_W-1:0]  PATTERN_LEN_RESET = 5'd1;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic [ADDR_W-1:0] byte_address;
    logic              last_byte;
  } in_t;

  typedef struct packed {
    logic              found;
    logic [ADDR_W-1:0] match_address;
  } out_t;

endpackage

// File: rtl/wildcard_byte_pattern_scanner_top.sv
// Wildcard byte pattern scanner, top level.
// Takes one byte per cycle while in_stall is low; each result is registered in
// the output register, or parked in a skid stage while the output stalls, and
// input stalls while the skid is full; the shift-window compare is combinational.
// Synchronous reset restores register defaults and starts a fresh scan.
`include "wildcard_byte_pattern_scanner_top_defines.svh"

module wildcard_byte_pattern_scanner_top #(
  parameter int MAX_PATTERN_BYTES = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  wbps_pkg::in_t                  in_item,
  output logic                           out_valid,
  input  logic                           out_stall,
  output wbps_pkg::out_t                 out_item,
  input  logic                           cfg_wr_en,
  input  logic [wbps_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [wbps_pkg::CFG_W-1:0]     cfg_data
);

  localparam int SEEN_W = $clog2(MAX_PATTERN_BYTES + 1);
  localparam logic [SEEN_W-1:0] SEEN_MAX = SEEN_W'(MAX_PATTERN_BYTES);

  // Configuration
  logic [wbps_pkg::CFG_W-1:0]  pattern_low;
  logic [wbps_pkg::CFG_W-1:0]  pattern_high;
  logic [wbps_pkg::MASK_W-1:0] care_mask;
  logic [wbps_pkg::LEN_W-1:0]  pattern_length;

  // Scan state
  logic [MAX_PATTERN_BYTES-1:0][wbps_pkg::BYTE_W-1:0] window;
  logic [MAX_PATTERN_BYTES-1:0][wbps_pkg::BYTE_W-1:0] window_next;
  logic [SEEN_W-1:0] bytes_seen;
  logic [SEEN_W-1:0] bytes_seen_next;
  logic              scan_done;

  // Output register and skid stage
  logic           skid_valid;
  wbps_pkg::out_t skid_item;

  logic                       in_xfer;
  logic                       out_xfer;
  logic                       match_hit;
  logic [wbps_pkg::LEN_W-1:0] eff_len;
  logic                       result_valid;
  wbps_pkg::out_t             result_item;

  assign in_stall = skid_valid;
  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid && !out_stall;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_low    <= '0;
      pattern_high   <= '0;
      care_mask      <= wbps_pkg::CARE_MASK_RESET;
      pattern_length <= wbps_pkg::PATTERN_LEN_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        wbps_pkg::REG_PATTERN_LOW:  pattern_low    <= cfg_data;
        wbps_pkg::REG_PATTERN_HIGH: pattern_high   <= cfg_data;
        wbps_pkg::REG_CARE_MASK:    care_mask      <= cfg_data[wbps_pkg::MASK_W-1:0];
        wbps_pkg::REG_PATTERN_LEN:  pattern_length <= cfg_data[wbps_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Shift the new byte in, newest at index 0
  always_comb begin
    window_next[0] = in_item.data_byte;
    for (int i = 1; i < MAX_PATTERN_BYTES; i++) begin
      window_next[i] = window[i-1];
    end
  end

  assign bytes_seen_next = (bytes_seen < SEEN_MAX) ? bytes_seen + SEEN_W'(1) : bytes_seen;

  wbps_match #(
    .MAX_PATTERN_BYTES(MAX_PATTERN_BYTES)
  ) u_match (
    .window_next    (window_next),
    .pattern        ({pattern_high, pattern_low}),
    .care_mask      (care_mask),
    .pattern_length (pattern_length),
    .bytes_seen_next(bytes_seen_next),
    .hit            (match_hit),
    .eff_len        (eff_len)
  );

  // Build the result: a match, or not-found at the end of the range
  assign result_valid = in_xfer && !scan_done && (match_hit || in_item.last_byte);
  always_comb begin
    result_item.found = match_hit;
    if (match_hit) begin
      result_item.match_address = in_item.byte_address
                                - wbps_pkg::ADDR_W'(eff_len - wbps_pkg::LEN_W'(1));
    end else begin
      result_item.match_address = '0;
    end
  end

  // Advance scan state on transfers until a match; the last byte starts over
  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_seen <= '0;
      scan_done  <= 1'b0;
    end else if (in_xfer) begin
      if (in_item.last_byte) begin
        bytes_seen <= '0;
        scan_done  <= 1'b0;
      end else if (!scan_done) begin
        bytes_seen <= bytes_seen_next;
        scan_done  <= match_hit;
      end
    end
  end

  // Hold window bytes; only positions below bytes_seen are ever compared
  always_ff @(posedge clk) begin
    if (in_xfer && !scan_done) begin
      window <= window_next;
    end
  end

  // Load the output register, or park the result in the skid stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_xfer) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= result_valid;
      end
    end else if (result_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_xfer) begin
      out_item <= skid_valid ? skid_item : result_item;
    end
    if (out_valid && !out_xfer && result_valid) begin
      skid_item <= result_item;
    end
  end

  // Checks
  `WBPS_ASSERT(a_skid_behind_out, clk, rst, skid_valid |-> out_valid, "skid holds data with empty output")
  `WBPS_ASSERT(a_not_found_zero, clk, rst, (out_valid && !out_item.found) |-> (out_item.match_address == '0), "not-found result carries an address")
  `WBPS_ASSERT_NEXT(a_done_after_hit, clk, rst, in_xfer && !scan_done && match_hit && !in_item.last_byte, scan_done, "scan not closed after a match")
  `WBPS_ASSERT(a_seen_bound, clk, rst, bytes_seen <= SEEN_MAX, "byte count past window depth")

endmodule

// File: rtl/wbps_match.sv
// Masked window compare for the wildcard byte pattern scanner.
// Depends on wbps_pkg for widths.
module wbps_match #(
  parameter int MAX_PATTERN_BYTES = 16
) (
  input  logic [MAX_PATTERN_BYTES-1:0][wbps_pkg::BYTE_W-1:0] window_next,
  input  logic [wbps_pkg::PATTERN_W-1:0]                     pattern,
  input  logic [wbps_pkg::MASK_W-1:0]                        care_mask,
  input  logic [wbps_pkg::LEN_W-1:0]                         pattern_length,
  input  logic [$clog2(MAX_PATTERN_BYTES+1)-1:0]             bytes_seen_next,
  output logic                                               hit,
  output logic [wbps_pkg::LEN_W-1:0]                         eff_len
);

  localparam int IDX_W = (MAX_PATTERN_BYTES > 1) ? $clog2(MAX_PATTERN_BYTES) : 1;
  localparam logic [wbps_pkg::LEN_W-1:0] MAX_LEN = wbps_pkg::LEN_W'(MAX_PATTERN_BYTES);

  logic all_ok;

  // Clamp the programmed length into the supported range
  always_comb begin
    if (pattern_length == '0) begin
      eff_len = wbps_pkg::LEN_W'(1);
    end else if (pattern_length > MAX_LEN) begin
      eff_len = MAX_LEN;
    end else begin
      eff_len = pattern_length;
    end
  end

  // Compare each pattern byte with its window byte; wildcards always pass.
  // Pattern byte i lines up with the byte taken eff_len-1-i items ago.
  always_comb begin
    logic [wbps_pkg::LEN_W-1:0] pos;
    all_ok = 1'b1;
    pos    = '0;
    for (int i = 0; i < MAX_PATTERN_BYTES; i++) begin
      pos = eff_len - wbps_pkg::LEN_W'(i) - wbps_pkg::LEN_W'(1);
      if ((wbps_pkg::LEN_W'(i) < eff_len) && care_mask[i] &&
          (pattern[8*i +: 8] != window_next[pos[IDX_W-1:0]])) begin
        all_ok = 1'b0;
      end
    end
  end

  // No match until the window holds a full pattern length of bytes
  assign hit = all_ok && (wbps_pkg::LEN_W'(bytes_seen_next) >= eff_len);

endmodule

// File: verif/wildcard_byte_pattern_scanner_top_test.sv
// Self-checking testbench for the wildcard byte pattern scanner top level.
// Predicts found/not-found reports from its own scan model; needs wbps_pkg
// and wildcard_byte_pattern_scanner_top.
module wildcard_byte_pattern_scanner_top_test;

  localparam int WINDOW_BYTES  = 16;
  localparam int SETTLE_CYCLES = 4;
  localparam int HOLD_CYCLES   = 300;
  localparam int CYCLE_LIMIT   = 400000;

  logic           clk;
  logic           rst;
  logic           in_valid;
  logic           in_stall;
  wbps_pkg::in_t  in_item;
  logic           out_valid;
  logic           out_stall;
  wbps_pkg::out_t out_item;
  logic           cfg_wr_en;
  logic [wbps_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [wbps_pkg::CFG_W-1:0]     cfg_data;

  // Scan model state and its copy of the registers
  logic [wbps_pkg::CFG_W-1:0]  pattern_lo;
  logic [wbps_pkg::CFG_W-1:0]  pattern_hi;
  logic [wbps_pkg::MASK_W-1:0] care_bits;
  logic [wbps_pkg::LEN_W-1:0]  len_reg;
  logic [7:0]                  window_bytes [WINDOW_BYTES];
  int                          seen_count;
  bit                          scan_hit_done;
  wbps_pkg::out_t              pending_reports [$];

  // Stimulus control
  logic [7:0] alpha [4];
  int         send_idle_pct;
  int         recv_idle_pct;
  bit         hold_req;
  int         hold_left;
  int         sent_items;
  int         fail_count;
  int         cycle_count;

  wildcard_byte_pattern_scanner_top uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Bound the run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic int eff_len();
    int n;
    n = len_reg;
    if (n == 0) n = 1;
    if (n > WINDOW_BYTES) n = WINDOW_BYTES;
    return n;
  endfunction

  function automatic logic [7:0] pattern_byte(int i);
    logic [wbps_pkg::PATTERN_W-1:0] p;
    p = {pattern_hi, pattern_lo};
    return p[8*i +: 8];
  endfunction

  function automatic void clear_scan();
    for (int k = 0; k < WINDOW_BYTES; k++) window_bytes[k] = 8'h00;
    seen_count = 0;
    scan_hit_done = 1'b0;
  endfunction

  // Shift one byte into the window and queue the report it causes, if any
  task automatic scan_step(input wbps_pkg::in_t it);
    int             n;
    bit             hit;
    wbps_pkg::out_t rep;
    sent_items++;
    if (!scan_hit_done) begin
      for (int k = WINDOW_BYTES - 1; k > 0; k--) window_bytes[k] = window_bytes[k-1];
      window_bytes[0] = it.data_byte;
      if (seen_count < WINDOW_BYTES) seen_count++;
      n = eff_len();
      hit = (seen_count >= n);
      for (int k = 0; k < n; k++) begin
        if (hit && care_bits[k] && pattern_byte(k) != window_bytes[n-1-k]) hit = 1'b0;
      end
      if (hit) begin
        rep.found = 1'b1;
        rep.match_address = it.byte_address - 32'(n - 1);
        pending_reports = {pending_reports, rep};
        scan_hit_done = 1'b1;
      end else if (it.last_byte) begin
        rep = '0;
        pending_reports = {pending_reports, rep};
      end
    end
    if (it.last_byte) clear_scan();
  endtask

  // Predict on every input transfer
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) scan_step(in_item);
  end

  // Compare every output transfer with the oldest queued report
  always @(posedge clk) begin
    wbps_pkg::out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_reports.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected report expected none got found=%b addr=%h",
                 $time, out_item.found, out_item.match_address);
      end else begin
        want = pending_reports.pop_front();
        if (out_item.found !== want.found ||
            out_item.match_address !== want.match_address) begin
          fail_count++;
          $display("%0t: report mismatch expected found=%b addr=%h got found=%b addr=%h",
                   $time, want.found, want.match_address,
                   out_item.found, out_item.match_address);
        end
      end
    end
  end

  // Output stall: random, or a long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      hold_left = 0;
    end else begin
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
    end
  end

  // Offer one byte and hold it until the transfer; then idle cycle by cycle
  task automatic send_byte(input logic [7:0] d, input logic [wbps_pkg::ADDR_W-1:0] a,
                           input logic l);
    in_item <= '{data_byte: d, byte_address: a, last_byte: l};
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Drop valid and wait until every queued report has come out
  task automatic wait_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [wbps_pkg::CFG_IDX_W-1:0] idx,
                           input logic [wbps_pkg::CFG_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      wbps_pkg::REG_PATTERN_LOW:  pattern_lo = val;
      wbps_pkg::REG_PATTERN_HIGH: pattern_hi = val;
      wbps_pkg::REG_CARE_MASK:    care_bits = val[wbps_pkg::MASK_W-1:0];
      wbps_pkg::REG_PATTERN_LEN:  len_reg = val[wbps_pkg::LEN_W-1:0];
      default: ;
    endcase
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  // Pattern from a small alphabet so scans built from it hit often
  task automatic pick_random_config();
    int                             r;
    logic [wbps_pkg::LEN_W-1:0]     len_v;
    logic [wbps_pkg::MASK_W-1:0]    mask_v;
    logic [wbps_pkg::PATTERN_W-1:0] pat;
    logic [wbps_pkg::CFG_W-1:0]     junk;
    for (int k = 0; k < 4; k++) alpha[k] = 8'($urandom);
    r = $urandom_range(0, 99);
    if (r < 5) len_v = 5'd0;
    else if (r < 12) len_v = 5'($urandom_range(17, 31));
    else if (r < 75) len_v = 5'($urandom_range(1, 6));
    else len_v = 5'($urandom_range(7, 16));
    mask_v = '1;
    if ($urandom_range(0, 99) < 35) begin
      for (int k = 0; k < wbps_pkg::MASK_W; k++) begin
        if ($urandom_range(0, 3) == 0) mask_v[k] = 1'b0;
      end
    end
    for (int k = 0; k < WINDOW_BYTES; k++) pat[8*k +: 8] = alpha[$urandom_range(0, 3)];
    write_reg(wbps_pkg::REG_PATTERN_LOW, pat[wbps_pkg::CFG_W-1:0]);
    write_reg(wbps_pkg::REG_PATTERN_HIGH, pat[wbps_pkg::PATTERN_W-1:wbps_pkg::CFG_W]);
    junk = {$urandom, $urandom};
    write_reg(wbps_pkg::REG_CARE_MASK, {junk[wbps_pkg::CFG_W-1:wbps_pkg::MASK_W], mask_v});
    junk = {$urandom, $urandom};
    write_reg(wbps_pkg::REG_PATTERN_LEN, {junk[wbps_pkg::CFG_W-1:wbps_pkg::LEN_W], len_v});
  endtask

  // One scan of mostly consecutive addresses, often with the pattern planted
  task automatic run_scan();
    logic [7:0]                  scan_bytes [$];
    int                          n;
    int                          eff;
    int                          start;
    bit                          noise;
    logic [wbps_pkg::ADDR_W-1:0] addr;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 16);
    noise = ($urandom_range(0, 9) == 0);
    for (int k = 0; k < n; k++) begin
      scan_bytes = {scan_bytes, (noise ? 8'($urandom) : alpha[$urandom_range(0, 3)])};
    end
    eff = eff_len();
    if (!noise && $urandom_range(0, 99) < 60) begin
      start = $urandom_range(0, n - 1);
      for (int k = 0; k < eff && start + k < n; k++) begin
        if (care_bits[k]) scan_bytes[start + k] = pattern_byte(k);
      end
    end
    addr = ($urandom_range(0, 4) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 20) : $urandom;
    for (int k = 0; k < n; k++) begin
      // break the address run now and then
      if ($urandom_range(0, 49) == 0) addr = $urandom;
      send_byte(scan_bytes[k], addr, (k == n - 1) && ($urandom_range(0, 9) != 0));
      addr++;
    end
  endtask

  // Register defaults: a single zero byte must match
  task automatic test_reset_defaults();
    send_byte(8'h00, 32'h0000_0010, 1'b0);
    send_byte(8'hFF, 32'h0000_0011, 1'b1);
    send_byte(8'hFF, 32'hFFFF_FFFF, 1'b1);
    wait_drain();
  endtask

  // Length zero acts as one; lengths above the window act as full window
  task automatic test_length_limits();
    logic [wbps_pkg::MASK_W-1:0] mask_v;
    write_reg(wbps_pkg::REG_PATTERN_LEN, 64'd0);
    write_reg(wbps_pkg::REG_PATTERN_LOW, 64'h0000_0000_0000_00FF);
    send_byte(8'hFF, 32'h0000_0020, 1'b1);
    wait_drain();
    mask_v = 16'h6DB6;
    write_reg(wbps_pkg::REG_PATTERN_LOW, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(wbps_pkg::REG_PATTERN_HIGH, 64'h0);
    write_reg(wbps_pkg::REG_CARE_MASK, {48'h0, mask_v});
    write_reg(wbps_pkg::REG_PATTERN_LEN, 64'd31);
    // full-window match that wraps the address space
    for (int k = 0; k < WINDOW_BYTES; k++) begin
      send_byte(mask_v[k] ? (k < 8 ? 8'hFF : 8'h00) : (k < 8 ? 8'h3C : 8'hC3),
                32'hFFFF_FFF5 + 32'(k), k == WINDOW_BYTES - 1);
    end
    wait_drain();
  endtask

  // A partial match that fails must not hide a start one byte later
  task automatic test_overlapping_start();
    write_reg(wbps_pkg::REG_PATTERN_LOW, 64'h0000_0000_0042_4141);
    write_reg(wbps_pkg::REG_CARE_MASK, 64'hFFFF);
    write_reg(wbps_pkg::REG_PATTERN_LEN, 64'd3);
    send_byte(8'h41, 32'h0000_0100, 1'b0);
    send_byte(8'h41, 32'h0000_0101, 1'b0);
    send_byte(8'h41, 32'h0000_0102, 1'b0);
    send_byte(8'h42, 32'h0000_0103, 1'b1);
    wait_drain();
  endtask

  // All wildcards, but the scan ends before enough bytes arrive
  task automatic test_short_scan();
    write_reg(wbps_pkg::REG_CARE_MASK, 64'h0);
    write_reg(wbps_pkg::REG_PATTERN_LEN, 64'd4);
    send_byte(8'h12, 32'h8000_0000, 1'b0);
    send_byte(8'h34, 32'h8000_0001, 1'b0);
    send_byte(8'h56, 32'h8000_0002, 1'b1);
    wait_drain();
  endtask

  // Hold the output off while every byte makes a report
  task automatic test_backpressure();
    int saved_pct;
    saved_pct = send_idle_pct;
    send_idle_pct = 0;
    write_reg(wbps_pkg::REG_PATTERN_LOW, 64'h5A);
    write_reg(wbps_pkg::REG_CARE_MASK, 64'hFFFF);
    write_reg(wbps_pkg::REG_PATTERN_LEN, 64'd1);
    hold_req = 1'b1;
    for (int k = 0; k < 24; k++) send_byte(8'h5A, $urandom, 1'b1);
    wait_drain();
    send_idle_pct = saved_pct;
  endtask

  task automatic test_random_scans(input int target, input int send_pct, input int recv_pct);
    int first;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    wait_drain();
    pick_random_config();
    first = sent_items;
    while (sent_items - first < target) begin
      // reconfigure now and then, sometimes in the middle of a scan
      if ($urandom_range(0, 99) < 15) begin
        wait_drain();
        pick_random_config();
      end
      run_scan();
    end
    wait_drain();
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_item = '0;
    cfg_wr_en = 1'b0;
    cfg_index = wbps_pkg::REG_PATTERN_LOW;
    cfg_data = '0;
    pattern_lo = '0;
    pattern_hi = '0;
    care_bits = wbps_pkg::CARE_MASK_RESET;
    len_reg = wbps_pkg::PATTERN_LEN_RESET;
    clear_scan();
    hold_req = 1'b0;
    sent_items = 0;
    fail_count = 0;
    cycle_count = 0;
    send_idle_pct = 32;
    recv_idle_pct = 66;
    for (int k = 0; k < 4; k++) alpha[k] = 8'h00;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_defaults();
    test_length_limits();
    test_overlapping_start();
    test_short_scan();
    test_backpressure();
    test_random_scans(150, 32, 66);
    test_random_scans(150, 66, 32);
    test_random_scans(150, 0, 0);

    repeat (8) @(posedge clk);
    if (fail_count == 0 && pending_reports.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
